// ----- hdl/key_click_long_press_classifier_defines.svh -----
// Assertion macros shared by the key click classifier modules.
`ifndef KEY_CLICK_LONG_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_CLICK_LONG_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KCL_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KCL_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/kcl_pkg.sv -----
// Shared types, codes and widths for the key click classifier.
package kcl_pkg;

  localparam int unsigned KEYBOARD_KEYS = 12;
  localparam int unsigned MOUSE_L_LANE  = 12;
  localparam int unsigned MOUSE_R_LANE  = 13;
  localparam int unsigned OUT_LANES     = 14;

  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned STATES_W  = OUT_LANES * STATUS_W;  // 28
  localparam int unsigned TOGGLES_W = OUT_LANES;             // 14

  localparam int unsigned IN_TDATA_W  = 48;  // 46 bits of fields, byte padded
  localparam int unsigned OUT_TDATA_W = 72;  // 70 bits of fields, byte padded

  // Input item bit positions
  localparam int unsigned IN_KEYS_LSB  = 0;
  localparam int unsigned IN_ML_BIT    = 12;
  localparam int unsigned IN_MR_BIT    = 13;
  localparam int unsigned IN_NOW_LSB   = 14;

  // Result item bit positions
  localparam int unsigned OUT_ST_LSB   = 0;
  localparam int unsigned OUT_LST_LSB  = 28;
  localparam int unsigned OUT_TG_LSB   = 56;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_L    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_R    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 2'd3;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;
  localparam logic [HOLD_W-1:0] GAP_RESET  = 16'd325;

  // Status codes as they appear in a result item
  localparam logic [STATUS_W-1:0] CODE_RELAX = 2'd0;
  localparam logic [STATUS_W-1:0] CODE_DOWN  = 2'd1;
  localparam logic [STATUS_W-1:0] CODE_CLICK = 2'd2;
  localparam logic [STATUS_W-1:0] CODE_PRESS = 2'd3;

  typedef enum logic [3:0] {
    ST_RELAX = 4'b0001,
    ST_DOWN  = 4'b0010,
    ST_CLICK = 4'b0100,
    ST_PRESS = 4'b1000
  } lane_state_e;

  // What one lane hands to the merge stage for the item being taken
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STATUS_W-1:0] prev_status;
    logic                toggle;
  } lane_out_t;

  function automatic logic [STATUS_W-1:0] status_code(lane_state_e st);
    logic [STATUS_W-1:0] code;
    case (st)
      ST_RELAX: code = CODE_RELAX;
      ST_DOWN:  code = CODE_DOWN;
      ST_CLICK: code = CODE_CLICK;
      ST_PRESS: code = CODE_PRESS;
      default:  code = CODE_RELAX;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/kcl_lane.sv -----
// One key lane: press count, status machine, click time and toggle.
`include "key_click_long_press_classifier_defines.svh"

module kcl_lane #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,     // item taken this cycle
  input  logic                         pressed_i,
  input  logic [kcl_pkg::HOLD_W-1:0]   hold_i,
  input  logic [kcl_pkg::HOLD_W-1:0]   gap_i,
  input  logic [kcl_pkg::TIME_W-1:0]   now_i,
  output kcl_pkg::lane_out_t           next_o
);
  import kcl_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

  lane_state_e           st_q, st_d, st_mid;
  logic [STATUS_W-1:0]   last_q, last_d, last_mid;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [TIME_W-1:0]     click_q, click_d, elapsed;
  logic                  tog_q, tog_d;
  logic                  gap_ok;

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign elapsed = now_i - click_q;  // wraps modulo 2^32
  assign gap_ok  = elapsed > TIME_W'(gap_i);

  always_comb begin
    st_d     = st_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    click_d  = click_q;
    tog_d    = tog_q;
    st_mid   = st_q;
    last_mid = last_q;
    if (!pressed_i) begin
      last_d = status_code(st_q);
      st_d   = ST_RELAX;
      cnt_d  = '0;
    end else begin
      cnt_d = cnt_inc;
      case (st_q)
        ST_RELAX: begin
          st_mid   = ST_DOWN;
          last_mid = CODE_RELAX;
        end
        ST_DOWN: begin
          if (gap_ok) begin
            st_mid   = ST_CLICK;
            last_mid = CODE_DOWN;
            click_d  = now_i;
            tog_d    = ~tog_q;
          end
        end
        default: ;
      endcase
      if (CMP_W'(cnt_inc) > CMP_W'(hold_i)) begin
        last_d = status_code(st_mid);
        st_d   = ST_PRESS;
      end else begin
        last_d = last_mid;
        st_d   = st_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_RELAX;
      last_q  <= CODE_RELAX;
      cnt_q   <= '0;
      click_q <= '0;
      tog_q   <= 1'b0;
    end else if (load_i) begin
      st_q    <= st_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      click_q <= click_d;
      tog_q   <= tog_d;
    end
  end

  assign next_o.status      = status_code(st_d);
  assign next_o.prev_status = last_d;
  assign next_o.toggle      = tog_d;

  `KCL_ASSERT_NOW(a_pressed_leaves_relax, clk_i, rst_ni, load_i && pressed_i, next_o.status != CODE_RELAX, "pressed key reported relax")
  `KCL_ASSERT_NEXT(a_release_clears, clk_i, rst_ni, load_i && !pressed_i, st_q == ST_RELAX && cnt_q == '0, "release did not clear lane")
  `KCL_ASSERT_NEXT(a_idle_holds, clk_i, rst_ni, !load_i, $stable(cnt_q) && $stable(tog_q) && $stable(click_q), "lane state moved without an item")

endmodule

// ----- hdl/kcl_merge.sv -----
// Merge stage: packs lane results into one output item and holds it.
`include "key_click_long_press_classifier_defines.svh"

module kcl_merge #(
  parameter int unsigned NUM_KEYS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  kcl_pkg::lane_out_t                  lanes_i [NUM_KEYS],
  input  logic                                m_ready_i,
  output logic                                m_valid_o,
  output logic [kcl_pkg::OUT_TDATA_W-1:0]     m_data_o,
  output logic                                slot_free_o
);
  import kcl_pkg::*;

  localparam int unsigned SHOWN = (NUM_KEYS < OUT_LANES) ? NUM_KEYS : OUT_LANES;

  logic                   valid_q, valid_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic [STATES_W-1:0]    states, last_states;
  logic [TOGGLES_W-1:0]   toggles;

  always_comb begin
    states      = '0;
    last_states = '0;
    toggles     = '0;
    for (int i = 0; i < SHOWN; i++) begin
      states[STATUS_W*i +: STATUS_W]      = lanes_i[i].status;
      last_states[STATUS_W*i +: STATUS_W] = lanes_i[i].prev_status;
      toggles[i]                          = lanes_i[i].toggle;
    end
  end

  assign data_d      = {2'b00, toggles, last_states, states};
  assign slot_free_o = !valid_q || m_ready_i;
  assign valid_d     = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

  `KCL_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, load_i, valid_q, "taken item not presented")
  `KCL_ASSERT_NEXT(a_drain_empties, clk_i, rst_ni, valid_q && m_ready_i && !load_i, !valid_q, "delivered item presented twice")

endmodule

// ----- hdl/key_click_long_press_classifier.sv -----
// Top level of the key click / long-press classifier.
//
// Channels: the slave stream takes one sample per item (12 keyboard keys,
// both mouse buttons and a 32-bit ms tick); the master stream returns one
// result per item with the status, previous status and click toggle of
// each of the 14 keys. Configuration is a plain write port: cfg_we_i,
// cfg_idx_i (0 key hold, 1 left hold, 2 right hold, 3 click gap),
// cfg_data_i; write only while no item is in flight.
// The result of an item appears on the master side in the cycle after it
// is taken. The block takes one item per cycle while the receiver keeps
// tready high; every lane updates its own state in the cycle the item is
// taken, and a single output register holds the merged result.
// Reset: all keys relax, counts, click times and toggles zero, hold
// thresholds 100 and click gap 325 ms; the master side is empty.
// Stall: while the receiver holds tready low the result register keeps
// its item and s_axis_tready drops; once the result is taken, a new item
// may be accepted in the same cycle.
module key_click_long_press_classifier #(
  parameter int unsigned NUM_KEYS   = 14,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [kcl_pkg::HOLD_W-1:0]           cfg_data_i,
  // Sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_bits[11:0], mouse_left[12], mouse_right[13], now_ms[45:14], zero pad
  input  logic [kcl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // key_states[27:0], key_last_states[55:28], click_toggles[69:56], zero pad
  output logic [kcl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import kcl_pkg::*;

  logic [HOLD_W-1:0] key_hold_q, mouse_l_hold_q, mouse_r_hold_q, click_gap_q;

  logic                     item_take;
  logic                     slot_free;
  logic [KEYBOARD_KEYS-1:0] key_bits;
  logic                     mouse_left, mouse_right;
  logic [TIME_W-1:0]        now_ms;
  lane_out_t                lane_out [NUM_KEYS];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hold_q     <= HOLD_RESET;
      mouse_l_hold_q <= HOLD_RESET;
      mouse_r_hold_q <= HOLD_RESET;
      click_gap_q    <= GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_HOLD:  key_hold_q     <= cfg_data_i;
        REG_MOUSE_L:   mouse_l_hold_q <= cfg_data_i;
        REG_MOUSE_R:   mouse_r_hold_q <= cfg_data_i;
        REG_CLICK_GAP: click_gap_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the sample
  assign key_bits    = s_axis_tdata[IN_KEYS_LSB +: KEYBOARD_KEYS];
  assign mouse_left  = s_axis_tdata[IN_ML_BIT];
  assign mouse_right = s_axis_tdata[IN_MR_BIT];
  assign now_ms      = s_axis_tdata[IN_NOW_LSB +: TIME_W];

  assign s_axis_tready = slot_free;
  assign item_take     = s_axis_tvalid && s_axis_tready;

  // One lane per key; lanes past the mouse buttons are never pressed
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    logic              pressed;
    logic [HOLD_W-1:0] hold;

    if (g < KEYBOARD_KEYS) begin : g_kbd
      assign pressed = key_bits[g];
      assign hold    = key_hold_q;
    end else if (g == MOUSE_L_LANE) begin : g_ml
      assign pressed = mouse_left;
      assign hold    = mouse_l_hold_q;
    end else if (g == MOUSE_R_LANE) begin : g_mr
      assign pressed = mouse_right;
      assign hold    = mouse_r_hold_q;
    end else begin : g_spare
      assign pressed = 1'b0;
      assign hold    = key_hold_q;
    end

    kcl_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .load_i    (item_take),
      .pressed_i (pressed),
      .hold_i    (hold),
      .gap_i     (click_gap_q),
      .now_i     (now_ms),
      .next_o    (lane_out[g])
    );
  end

  kcl_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (item_take),
    .lanes_i     (lane_out),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_data_o    (m_axis_tdata),
    .slot_free_o (slot_free)
  );

endmodule

// ----- sim/key_click_long_press_classifier_tb.sv -----
// Self-checking testbench for the key click / long-press classifier.
module key_click_long_press_classifier_tb;
  import kcl_pkg::*;

  localparam int unsigned LANES           = OUT_LANES;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTED    = 10;
  localparam logic [HOLD_W-1:0] COUNT_MAX = '1;     // COUNT_BITS is 16 here

  // Sample item as it sits in tdata; last field in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic                      mouse_right;
    logic                      mouse_left;
    logic [KEYBOARD_KEYS-1:0]  key_bits;
  } key_sample_t;

  // Result item, same packing rule
  typedef struct packed {
    logic [TOGGLES_W-1:0] click_toggles;
    logic [STATES_W-1:0]  key_last_states;
    logic [STATES_W-1:0]  key_states;
  } status_report_t;

  // Tracks every lane's classifier state and holds the reports still owed
  class key_status_scoreboard;
    logic [HOLD_W-1:0]   hold_key, hold_ml, hold_mr, gap_ms;
    logic [STATUS_W-1:0] status [LANES];
    logic [STATUS_W-1:0] prev_status [LANES];
    logic [HOLD_W-1:0]   press_count [LANES];
    logic [TIME_W-1:0]   click_time [LANES];
    logic                toggle [LANES];
    status_report_t      reports_due[$];
    int unsigned         mismatches;

    function new();
      hold_key   = HOLD_RESET;
      hold_ml    = HOLD_RESET;
      hold_mr    = HOLD_RESET;
      gap_ms     = GAP_RESET;
      mismatches = 0;
      foreach (status[i]) begin
        status[i]      = CODE_RELAX;
        prev_status[i] = CODE_RELAX;
        press_count[i] = '0;
        click_time[i]  = '0;
        toggle[i]      = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] value);
      case (idx)
        REG_KEY_HOLD:  hold_key = value;
        REG_MOUSE_L:   hold_ml  = value;
        REG_MOUSE_R:   hold_mr  = value;
        REG_CLICK_GAP: gap_ms   = value;
        default: ;
      endcase
    endfunction

    function void predict_sample(key_sample_t smp);
      status_report_t    rep;
      logic              pressed;
      logic [HOLD_W-1:0] hold;
      logic [TIME_W-1:0] elapsed;
      rep = '0;
      for (int i = 0; i < LANES; i++) begin
        if (i < KEYBOARD_KEYS) begin
          pressed = smp.key_bits[i];
          hold    = hold_key;
        end else if (i == MOUSE_L_LANE) begin
          pressed = smp.mouse_left;
          hold    = hold_ml;
        end else begin
          pressed = smp.mouse_right;
          hold    = hold_mr;
        end
        if (!pressed) begin
          prev_status[i] = status[i];
          status[i]      = CODE_RELAX;
          press_count[i] = '0;
        end else begin
          if (press_count[i] != COUNT_MAX) press_count[i] = press_count[i] + 1'b1;
          // elapsed time wraps at 32 bits
          elapsed = smp.now_ms - click_time[i];
          if (status[i] == CODE_RELAX) begin
            prev_status[i] = CODE_RELAX;
            status[i]      = CODE_DOWN;
          end else if (status[i] == CODE_DOWN && elapsed > TIME_W'(gap_ms)) begin
            click_time[i]  = smp.now_ms;
            prev_status[i] = CODE_DOWN;
            status[i]      = CODE_CLICK;
            toggle[i]      = ~toggle[i];
          end
          // long press wins over whatever the lane just became
          if (press_count[i] > hold) begin
            prev_status[i] = status[i];
            status[i]      = CODE_PRESS;
          end
        end
        rep.key_states[STATUS_W*i +: STATUS_W]      = status[i];
        rep.key_last_states[STATUS_W*i +: STATUS_W] = prev_status[i];
        rep.click_toggles[i]                        = toggle[i];
      end
      reports_due.push_back(rep);
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTED) $display("mismatch: %s", what);
    endfunction

    function void check_report(status_report_t got);
      status_report_t want;
      if (reports_due.size() == 0) begin
        note_mismatch($sformatf("result with nothing outstanding: %h", got));
        return;
      end
      want = reports_due.pop_front();
      if (got.key_states != want.key_states)
        note_mismatch($sformatf("key_states exp %h got %h",
                                want.key_states, got.key_states));
      if (got.key_last_states != want.key_last_states)
        note_mismatch($sformatf("key_last_states exp %h got %h",
                                want.key_last_states, got.key_last_states));
      if (got.click_toggles != want.click_toggles)
        note_mismatch($sformatf("click_toggles exp %h got %h",
                                want.click_toggles, got.click_toggles));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = REG_KEY_HOLD;
  logic [HOLD_W-1:0]      cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  key_status_scoreboard sb = new();

  // hold_off_req: sender asks for a long receiver stall; hold_off_active
  // stays high while it lasts so the sender keeps the input side busy
  bit          hold_off_req    = 1'b0;
  bit          hold_off_active = 1'b0;
  int unsigned quiet_cycles    = 0;

  key_click_long_press_classifier u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Both handshakes are observed at the rising edge; inputs only move on
  // the falling edge, so what is seen here is stable.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_report(m_axis_tdata[$bits(status_report_t)-1:0]);
      if (s_axis_tvalid && s_axis_tready)
        sb.predict_sample(s_axis_tdata[$bits(key_sample_t)-1:0]);
    end
  end

  // Ends the run if neither side moves an item for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL key_click_long_press_classifier");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random ready pattern, mostly short stalls, the odd long one,
  // plus the requested hold-off
  initial begin
    int unsigned r;
    int unsigned len;
    logic        rdy;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req    = 1'b0;
        hold_off_active = 1'b1;
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_active = 1'b0;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 50) begin
          rdy = 1'b1;
          len = $urandom_range(8, 1);
        end else if (r < 60) begin
          rdy = 1'b1;
          len = $urandom_range(120, 30);
        end else if (r < 90) begin
          rdy = 1'b0;
          len = $urandom_range(3, 1);
        end else if (r < 97) begin
          rdy = 1'b0;
          len = $urandom_range(12, 4);
        end else begin
          rdy = 1'b0;
          len = $urandom_range(60, 20);
        end
        @(negedge clk_i);
        m_axis_tready <= rdy;
        repeat (len - 1) @(negedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic key_sample_t mk_sample(logic [KEYBOARD_KEYS-1:0] keys, logic ml,
                                            logic mr, logic [TIME_W-1:0] now_ms);
    key_sample_t smp;
    smp.key_bits    = keys;
    smp.mouse_left  = ml;
    smp.mouse_right = mr;
    smp.now_ms      = now_ms;
    return smp;
  endfunction

  // Offers one item, waits for it to be taken, then holds tvalid low for the gap.
  // With gap 0 tvalid stays high into the next item.
  task automatic send_sample(key_sample_t smp, int unsigned gap);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - $bits(key_sample_t)){1'b0}}, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [HOLD_W-1:0] key_hold, logic [HOLD_W-1:0] ml_hold,
                           logic [HOLD_W-1:0] mr_hold, logic [HOLD_W-1:0] gap);
    drain();
    write_reg(REG_KEY_HOLD, key_hold);
    write_reg(REG_MOUSE_L, ml_hold);
    write_reg(REG_MOUSE_R, mr_hold);
    write_reg(REG_CLICK_GAP, gap);
  endtask

  // Mostly coherent key activity: each lane flips with chance 1/flip_div per
  // sample, so keys are held for runs of samples while time moves on in
  // steps scaled to the click gap. One sample in ten is random noise.
  task automatic run_random(int unsigned n, int unsigned flip_div, bit with_hold_off);
    logic [LANES-1:0]  held;
    logic [TIME_W-1:0] now_ms;
    key_sample_t       smp;
    int unsigned       r;
    int unsigned       span;
    held   = '0;
    now_ms = $urandom();
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold_off && i == n / 2) hold_off_req = 1'b1;
      for (int l = 0; l < LANES; l++)
        if ($urandom_range(flip_div - 1, 0) == 0) held[l] = ~held[l];
      span = sb.gap_ms / 4 + 4;
      r = $urandom_range(99, 0);
      if (r < 85)      now_ms = now_ms + $urandom_range(span, 0);
      else if (r < 95) now_ms = now_ms + sb.gap_ms + $urandom_range(span, 0);
      else if (r < 98) now_ms = $urandom();
      else             now_ms = 32'hFFFF_FFFF - $urandom_range(400, 0);
      if ($urandom_range(9, 0) == 0)
        smp = mk_sample(KEYBOARD_KEYS'($urandom()), 1'($urandom_range(1, 0)),
                        1'($urandom_range(1, 0)), now_ms);
      else
        smp = mk_sample(held[KEYBOARD_KEYS-1:0], held[MOUSE_L_LANE], held[MOUSE_R_LANE],
                        now_ms);
      send_sample(smp, (hold_off_req || hold_off_active) ? 0 : pick_gap());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings (gap 325, hold 100)
    send_sample(mk_sample('0, 1'b0, 1'b0, 32'd0), pick_gap());
    send_sample(mk_sample('1, 1'b1, 1'b1, 32'd0), pick_gap());           // relax to down
    send_sample(mk_sample('1, 1'b1, 1'b1, 32'd325), pick_gap());         // gap not exceeded
    send_sample(mk_sample('1, 1'b1, 1'b1, 32'd326), pick_gap());         // click, toggles flip
    send_sample(mk_sample('1, 1'b1, 1'b1, 32'd327), pick_gap());         // click held
    send_sample(mk_sample('0, 1'b0, 1'b0, 32'hFFFF_FFFF), pick_gap());   // all released
    send_sample(mk_sample(12'hAAA, 1'b1, 1'b0, 32'hFFFF_FFFF), pick_gap());
    send_sample(mk_sample(12'hAAA, 1'b1, 1'b0, 32'h0000_0010), pick_gap()); // wrapped diff
    send_sample(mk_sample(12'h555, 1'b0, 1'b1, 32'h8000_0000), pick_gap());
    send_sample(mk_sample(12'h555, 1'b0, 1'b1, 32'h8000_0000), pick_gap());
    send_sample(mk_sample(12'h555, 1'b0, 1'b1, 32'h8000_0146), pick_gap());
    send_sample(mk_sample(12'h555, 1'b0, 1'b1, 32'h8000_0147), pick_gap());
    send_sample(mk_sample(12'hFFF, 1'b1, 1'b1, 32'h7FFF_FFFF), pick_gap());
    send_sample(mk_sample(12'hFFF, 1'b1, 1'b1, 32'h5555_5555), pick_gap());
    send_sample(mk_sample(12'h0F0, 1'b0, 1'b1, 32'hAAAA_AAAA), pick_gap());
    send_sample(mk_sample(12'h0F0, 1'b0, 1'b1, 32'h0000_0001), pick_gap());

    // Zero thresholds: a pressed key goes straight to long press
    configure('0, '0, '0, '0);
    run_random(250, 6, 1'b0);

    // Small thresholds and gap, with the long receiver hold-off midway
    configure(16'd3, 16'd5, 16'd1, 16'd10);
    run_random(400, 8, 1'b1);

    // Top thresholds: no lane reaches long press; zero gap clicks at once
    configure(COUNT_MAX, COUNT_MAX, COUNT_MAX, '0);
    run_random(200, 4, 1'b0);

    // Mixed thresholds across lanes
    configure(16'd12, '0, COUNT_MAX, 16'd200);
    run_random(400, 10, 1'b0);

    configure(HOLD_W'($urandom_range(40, 1)), HOLD_W'($urandom_range(40, 1)),
              HOLD_W'($urandom_range(40, 1)), HOLD_W'($urandom_range(600, 0)));
    run_random(400, 8, 1'b1);

    // Reset values written back; long holds so lanes reach long press
    configure(HOLD_RESET, HOLD_RESET, HOLD_RESET, GAP_RESET);
    run_random(350, 150, 1'b0);

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS key_click_long_press_classifier");
    end else begin
      $display("FAIL key_click_long_press_classifier");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/kcl_pkg.sv
hdl/kcl_lane.sv
hdl/kcl_merge.sv
hdl/key_click_long_press_classifier.sv
sim/key_click_long_press_classifier_tb.sv
